[hdl/polyphase_fir_decimator_unit_macros.svh]
// Assertion macros for the polyphase FIR decimator.
// They expect signals named clk and rst_n in the scope where they are used.
`ifndef POLYPHASE_FIR_DECIMATOR_UNIT_MACROS_SVH
`define POLYPHASE_FIR_DECIMATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PFD_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pfd assertion failed: forbidden condition");
`define PFD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pfd assertion failed: expected follow-up missing");
`else
`define PFD_ASSERT_NEVER(label, cond)
`define PFD_ASSERT_NEXT(label, pre, post)
`endif
`endif

[hdl/pfd_pkg.sv]
package pfd_pkg;

    localparam int SMP_W      = 8;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SMP_W + COEF_W;
    localparam int ACC_W      = 32;
    localparam int OUT_W      = 16;
    localparam int OUT_LSB    = 7;
    localparam int TABLE_ROWS = 5;
    localparam int TABLE_COLS = 5;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    sample_last;
    } pfd_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    filtered_last;
    } pfd_out_t;

    // Q1.15 coefficients, one row per branch, truncated toward minus infinity.
    localparam logic signed [COEF_W-1:0] COEF_Q15 [TABLE_ROWS][TABLE_COLS] = '{
        '{  -16'sd73,   16'sd465,  16'sd4623,   16'sd630,   16'sd625 },
        '{ -16'sd227,  -16'sd458,  16'sd8572, -16'sd1542,   16'sd249 },
        '{  -16'sd98, -16'sd1562, 16'sd10222, -16'sd1562,   -16'sd98 },
        '{  16'sd249, -16'sd1542,  16'sd8572,  -16'sd458,  -16'sd227 },
        '{  16'sd625,   16'sd630,  16'sd4623,   16'sd465,   -16'sd73 }
    };

    // Entries outside the built-in table read as zero.
    function automatic logic signed [COEF_W-1:0] coef_at(input int row, input int col);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (row < TABLE_ROWS && col < TABLE_COLS)
        begin
            c = COEF_Q15[row][col];
        end
        return c;
    endfunction

endpackage

[hdl/pfd_ram.sv]
module pfd_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 5
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pfd_tap_mac.sv]
module pfd_tap_mac #(
    parameter int TAPS = 5,
    parameter int PH_W = 3
) (
    input  logic [TAPS*pfd_pkg::SMP_W-1:0]  row_old,
    input  logic                            row_ok,
    input  logic signed [pfd_pkg::SMP_W-1:0] sample,
    input  logic [PH_W-1:0]                 branch,
    output logic [TAPS*pfd_pkg::SMP_W-1:0]  row_new,
    output logic [TAPS*pfd_pkg::PROD_W-1:0] prods
);

    import pfd_pkg::*;

    logic signed [SMP_W-1:0]  tap_old [TAPS];
    logic signed [SMP_W-1:0]  tap_new [TAPS];
    logic signed [COEF_W-1:0] coef    [TAPS];
    logic signed [PROD_W-1:0] prod    [TAPS];

    // A row that was never written holds zeros.
    always_comb
    begin
        for (int t = 0; t < TAPS; t++)
        begin
            tap_old[t] = row_ok ? row_old[t*SMP_W +: SMP_W] : '0;
        end
        tap_new[0] = sample;
        for (int t = 1; t < TAPS; t++)
        begin
            tap_new[t] = tap_old[t-1];
        end
        for (int t = 0; t < TAPS; t++)
        begin
            coef[t] = coef_at(int'(branch), t);
            prod[t] = tap_new[t] * coef[t];
            row_new[t*SMP_W +: SMP_W]   = tap_new[t];
            prods[t*PROD_W +: PROD_W]   = prod[t];
        end
    end

endmodule

[hdl/polyphase_fir_decimator_unit.sv]
// A result word appears on flt once the last sample of its group has passed stage 1, stage 2 and the output register.
// Throughput: one sample word per cycle while smp_stall is low, one result word per PHASES samples.
// Each sample reads its branch row from the delay-line RAM and writes it back when it leaves stage 1.
// Reset clears the phase counter, accumulator, row valid bits and all pipeline valids.
// The delay-line RAM itself is not cleared; rows never written read as zero.
`include "polyphase_fir_decimator_unit_macros.svh"

module polyphase_fir_decimator_unit #(
    parameter int PHASES         = 5,
    parameter int TAPS_PER_PHASE = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              smp_valid,
    output logic              smp_stall,
    input  pfd_pkg::pfd_in_t  smp,
    output logic              flt_valid,
    input  logic              flt_stall,
    output pfd_pkg::pfd_out_t flt
);

    import pfd_pkg::*;

    localparam int PH_W  = $clog2(PHASES);
    localparam int ROW_W = TAPS_PER_PHASE * SMP_W;
    localparam int PRD_W = TAPS_PER_PHASE * PROD_W;

    // Sample-side control: the phase counter picks the branch, which runs
    // from the highest branch down to zero.
    logic [PH_W-1:0]   phase_reg;
    logic [PH_W-1:0]   branch_now;
    logic              emit_now;
    logic              accept;
    logic [PHASES-1:0] row_ok_reg;

    // Stage 1: RAM read data is valid, the row is shifted and written back.
    logic              s1_valid_reg;
    pfd_in_t           s1_word_reg;
    logic [PH_W-1:0]   s1_branch_reg;
    logic              s1_emit_reg;
    logic              s1_row_ok_reg;
    logic              s1_move;

    // Stage 2: registered products, summed into the accumulator.
    logic              s2_valid_reg;
    logic [PRD_W-1:0]  s2_prod_reg;
    logic              s2_emit_reg;
    logic              s2_last_reg;
    logic              s2_move;

    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  s2_sum;
    logic [ACC_W-1:0]  acc_sum;

    // Output register; it parts the result side from the sample side.
    logic              out_valid_reg;
    pfd_out_t          out_reg;
    pfd_out_t          out_next;
    logic              out_free;

    logic [ROW_W-1:0]  row_rd;
    logic [ROW_W-1:0]  row_new;
    logic [PRD_W-1:0]  prods;

    assign branch_now = PH_W'(PHASES - 1) - phase_reg;
    assign emit_now   = (phase_reg == PH_W'(PHASES - 1));

    // Only a word that must emit while the output register is occupied and
    // stalled blocks the pipe; every other word flows on.
    assign out_free  = !out_valid_reg || !flt_stall;
    assign s2_move   = s2_valid_reg && (!s2_emit_reg || out_free);
    assign s1_move   = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign smp_stall = s1_valid_reg && !s1_move;
    assign accept    = smp_valid && !smp_stall;

    // One row per branch. Consecutive samples always hit different rows, so
    // the write-back of a row lands before that row is read again.
    pfd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (PHASES)
    ) u_delay_ram (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_branch_reg),
        .wdata (row_new),
        .re    (accept),
        .raddr (branch_now),
        .rdata (row_rd)
    );

    pfd_tap_mac #(
        .TAPS (TAPS_PER_PHASE),
        .PH_W (PH_W)
    ) u_tap_mac (
        .row_old (row_rd),
        .row_ok  (s1_row_ok_reg),
        .sample  (s1_word_reg.sample),
        .branch  (s1_branch_reg),
        .row_new (row_new),
        .prods   (prods)
    );

    always_comb
    begin
        s2_sum = '0;
        for (int t = 0; t < TAPS_PER_PHASE; t++)
        begin
            s2_sum = s2_sum + ACC_W'($signed(s2_prod_reg[t*PROD_W +: PROD_W]));
        end
        acc_sum = acc_reg + s2_sum;
        out_next.filtered      = acc_sum[OUT_LSB +: OUT_W];
        out_next.filtered_last = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            row_ok_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= emit_now ? '0 : phase_reg + 1'b1;
            end
            if (s1_move)
            begin
                row_ok_reg[s1_branch_reg] <= 1'b1;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_move)
            begin
                acc_reg <= s2_emit_reg ? '0 : acc_sum;
            end
            if (s2_move && s2_emit_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!flt_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg   <= smp;
            s1_branch_reg <= branch_now;
            s1_emit_reg   <= emit_now;
            s1_row_ok_reg <= row_ok_reg[branch_now];
        end
        if (s1_move)
        begin
            s2_prod_reg <= prods;
            s2_emit_reg <= s1_emit_reg;
            s2_last_reg <= s1_word_reg.sample_last;
        end
        if (s2_move && s2_emit_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign flt_valid = out_valid_reg;
    assign flt       = out_reg;

    // An emitting word must show up on the output and leave a cleared sum.
    `PFD_ASSERT_NEXT(a_emit_shows, s2_move && s2_emit_reg, out_valid_reg && acc_reg == '0)
    // A sample word may never enter while stage 1 is held.
    `PFD_ASSERT_NEVER(a_no_accept_on_hold, accept && s1_valid_reg && !s1_move)
    // The fifth sample of a group returns the phase counter to zero.
    `PFD_ASSERT_NEXT(a_phase_wraps, accept && emit_now, phase_reg == '0)

endmodule

[tb/sv/fir_decim_checker.sv]
module fir_decim_checker #(
    parameter int PHASES         = 5,
    parameter int TAPS_PER_PHASE = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              smp_valid,
    input  logic              smp_stall,
    input  pfd_pkg::pfd_in_t  smp,
    input  logic              flt_valid,
    input  logic              flt_stall,
    input  pfd_pkg::pfd_out_t flt,
    output int                errors,
    output int                pending
);

    import pfd_pkg::*;

    logic signed [SMP_W-1:0] delay_line [PHASES][TAPS_PER_PHASE];
    int unsigned             phase;
    logic [ACC_W-1:0]        acc;
    pfd_out_t                decimated_q [$];
    int                      mismatches;

    // Shift the sample into its branch, add the branch dot product to the
    // running sum and queue a result word on the last branch of each round.
    task automatic accumulate_sample(input pfd_in_t w);
        int unsigned      branch;
        logic [ACC_W-1:0] branch_sum;
        int               prod;
        branch = PHASES - 1 - phase;
        for (int t = TAPS_PER_PHASE - 1; t > 0; t--)
        begin
            delay_line[branch][t] = delay_line[branch][t-1];
        end
        delay_line[branch][0] = w.sample;
        branch_sum = '0;
        for (int t = 0; t < TAPS_PER_PHASE; t++)
        begin
            // Taps outside the coefficient table contribute nothing.
            if (branch < TABLE_ROWS && t < TABLE_COLS)
            begin
                prod = int'(delay_line[branch][t]) * int'(COEF_Q15[branch][t]);
                branch_sum += prod;
            end
        end
        acc += branch_sum;
        if (phase == PHASES - 1)
        begin
            decimated_q.push_back('{filtered: acc[OUT_LSB +: OUT_W],
                                    filtered_last: w.sample_last});
            acc   = '0;
            phase = 0;
        end
        else
        begin
            phase++;
        end
    endtask

    task automatic compare_result(input pfd_out_t got);
        pfd_out_t want;
        if (decimated_q.size() == 0)
        begin
            $display("%0t: result word with none expected, expected none, got %0d last %0b",
                     $time, got.filtered, got.filtered_last);
            mismatches++;
        end
        else
        begin
            want = decimated_q.pop_front();
            if (got.filtered !== want.filtered)
            begin
                $display("%0t: filtered expected %0d, got %0d",
                         $time, want.filtered, got.filtered);
                mismatches++;
            end
            if (got.filtered_last !== want.filtered_last)
            begin
                $display("%0t: filtered_last expected %0b, got %0b",
                         $time, want.filtered_last, got.filtered_last);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < PHASES; b++)
            begin
                for (int t = 0; t < TAPS_PER_PHASE; t++)
                begin
                    delay_line[b][t] = '0;
                end
            end
            phase      = 0;
            acc        = '0;
            mismatches = 0;
            decimated_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (smp_valid && !smp_stall)
            begin
                accumulate_sample(smp);
            end
            if (flt_valid && !flt_stall)
            begin
                compare_result(flt);
            end
            errors  <= mismatches;
            pending <= decimated_q.size();
        end
    end

endmodule

[tb/sv/tb.sv]
module tb;
    import pfd_pkg::*;

    localparam int PHASES         = 5;
    localparam int TAPS_PER_PHASE = 5;
    // One full refill of every delay line; blocks of this many words keep the
    // stimulus aligned to the branch rotation.
    localparam int ROUND          = PHASES * TAPS_PER_PHASE;
    localparam int RANDOM_ROUNDS  = 78;

    logic     clk       = 1'b0;
    logic     rst_n;
    logic     smp_valid;
    logic     smp_stall;
    pfd_in_t  smp;
    logic     flt_valid;
    logic     flt_stall = 1'b0;
    pfd_out_t flt;

    // While steady is high neither the sample source nor the result sink idles.
    logic     steady    = 1'b0;
    int       errors;
    int       pending;

    always #1 clk = ~clk;

    polyphase_fir_decimator_unit #(
        .PHASES         (PHASES),
        .TAPS_PER_PHASE (TAPS_PER_PHASE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp       (smp),
        .flt_valid (flt_valid),
        .flt_stall (flt_stall),
        .flt       (flt)
    );

    fir_decim_checker #(
        .PHASES         (PHASES),
        .TAPS_PER_PHASE (TAPS_PER_PHASE)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp       (smp),
        .flt_valid (flt_valid),
        .flt_stall (flt_stall),
        .flt       (flt),
        .errors    (errors),
        .pending   (pending)
    );

    // The result sink stalls on about 16 percent of cycles, except during the
    // steady stretch, so that stalls land on every phase of the rotation.
    always @(posedge clk)
    begin
        flt_stall <= !steady && ($urandom_range(0, 99) < 16);
    end

    // Picks the sample for position pos of a round so that, once the round is
    // complete, every tap holds a full-scale value whose sign matches its
    // coefficient (or opposes it when toward_max is low). The sample taken at
    // round step r ends up at tap TAPS_PER_PHASE-1-r of its branch. This drives
    // the output well past the 16-bit range, so the result must wrap.
    function automatic logic signed [SMP_W-1:0] full_scale_sample(input logic toward_max,
                                                                   input int pos);
        int branch;
        int tap;
        branch = PHASES - 1 - (pos % PHASES);
        tap    = TAPS_PER_PHASE - 1 - (pos / PHASES);
        if ((COEF_Q15[branch][tap] >= 0) == toward_max)
        begin
            return 8'sd127;
        end
        return -8'sd128;
    endfunction

    // Offers one sample word and holds it until the block takes it. A random
    // number of idle cycles may come first; valid and the payload then stay
    // fixed across any stall. Stall is read at the edge itself, before the
    // block's registers move, so acceptance is judged exactly as the block sees it.
    task automatic send_sample(input logic signed [SMP_W-1:0] value, input logic last);
        while (!steady && $urandom_range(0, 99) < 16)
        begin
            smp_valid <= 1'b0;
            @(posedge clk);
        end
        smp_valid <= 1'b1;
        smp       <= '{sample: value, sample_last: last};
        @(posedge clk);
        while (smp_stall)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int                      style;
        logic signed [SMP_W-1:0] value;
        logic                    last;

        rst_n     <= 1'b0;
        smp_valid <= 1'b0;
        smp       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: one round of full-scale samples matched to the
        // coefficient signs. It starts from the cleared delay lines, uses both
        // sample extremes and ends with a result that overflows 16 bits. The
        // final word carries the last flag.
        for (int pos = 0; pos < ROUND; pos++)
        begin
            send_sample(full_scale_sample(1'b1, pos), pos == ROUND - 1);
        end

        // Random rounds. Each round has a style: mostly free random samples,
        // some full-scale rounds that overflow the output in either direction,
        // some tiny values near zero and some drawn from a few corner values.
        for (int rnd = 0; rnd < RANDOM_ROUNDS; rnd++)
        begin
            steady <= (rnd >= 30 && rnd < 46);
            style = $urandom_range(0, 9);
            for (int pos = 0; pos < ROUND; pos++)
            begin
                case (style)
                    5, 6:    value = full_scale_sample(1'b1, pos);
                    7:       value = full_scale_sample(1'b0, pos);
                    8:       value = SMP_W'($urandom_range(0, 8) - 4);
                    9:
                    begin
                        case ($urandom_range(0, 3))
                            0:       value = 8'sd127;
                            1:       value = -8'sd128;
                            2:       value = 8'sd0;
                            default: value = -8'sd1;
                        endcase
                    end
                    default: value = SMP_W'($urandom);
                endcase
                last = ($urandom_range(0, 7) == 0);
                send_sample(value, last);
            end
        end
        smp_valid <= 1'b0;
        steady    <= 1'b0;

        // Drain: the checker's count of queued words is registered, so step past
        // the last sample first. Then wait for every queued result word and keep
        // watching the output for any word that should not be there.
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (errors == 0 && pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run of about two thousand words.
    initial
    begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule

[polyphase_fir_decimator_unit.f]
+incdir+hdl
hdl/pfd_pkg.sv
hdl/pfd_ram.sv
hdl/pfd_tap_mac.sv
hdl/polyphase_fir_decimator_unit.sv
tb/sv/fir_decim_checker.sv
tb/sv/tb.sv
